// ----- hw/rtl/gtp_pkg.sv -----
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared widths, codes and payload types of the GCRA traffic policer.
// ----------------------------------------------------------------------------
package gtp_pkg;

    localparam int TIME_WIDTH        = 64;
    localparam int COUNT_WIDTH       = 16;
    localparam int FIELD_TIME_WIDTH  = 64;
    localparam int FIELD_COUNT_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH   = 2;

    typedef logic [TIME_WIDTH-1:0]      ticks_t;
    typedef logic [COUNT_WIDTH-1:0]     count_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam ticks_t TMAX = '1;

    localparam cfg_index_t CFG_INCREMENT = CFG_INDEX_WIDTH'(0);
    localparam cfg_index_t CFG_LIMIT     = CFG_INDEX_WIDTH'(1);

    typedef enum logic [1:0] {
        OP_EVALUATE = 2'd0,
        OP_COMMIT   = 2'd1,
        OP_ROLLBACK = 2'd2,
        OP_RESTART  = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t                      opcode;
        logic [FIELD_TIME_WIDTH-1:0]  timestamp;
        logic [FIELD_COUNT_WIDTH-1:0] unit_count;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_TIME_WIDTH-1:0] delay;
        logic                        pending_alarm;
        logic                        admitted;
        logic                        approximate;
    } out_item_t;

    typedef struct packed {
        ticks_t increment;
        ticks_t limit;
    } settings_t;

    typedef struct packed {
        opcode_t opcode;
        ticks_t  timestamp;
        ticks_t  charge;
        logic    overflow;
    } charge_t;

endpackage

// ----- hw/rtl/gtp_in_if.sv -----
// ----------------------------------------------------------------------------
// gtp_in_if
// Request channel of the policer: one opcode with its timestamp and count.
// ----------------------------------------------------------------------------
interface gtp_in_if
    import gtp_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gtp_out_if.sv -----
// ----------------------------------------------------------------------------
// gtp_out_if
// Result channel of the policer: delay and status flags for one request.
// ----------------------------------------------------------------------------
interface gtp_out_if
    import gtp_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gtp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// gtp_cfg_if
// Register write channel of the policer.
// ----------------------------------------------------------------------------
interface gtp_cfg_if
    import gtp_pkg::*;
();
    logic                        valid;
    logic                        ready;
    cfg_index_t                  index;
    logic [FIELD_TIME_WIDTH-1:0] value;

    modport source (output valid, output index, output value, input ready);
    modport sink (input valid, input index, input value, output ready);
endinterface

// ----- hw/rtl/gtp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// gtp_cfg_regs
// Increment and limit registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module gtp_cfg_regs
    import gtp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    gtp_cfg_if.sink          cfg,
    output settings_t        settings
);

    ticks_t increment_reg;
    ticks_t increment_next;
    ticks_t limit_reg;
    ticks_t limit_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        increment_next = increment_reg;
        limit_next     = limit_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_INCREMENT: increment_next = cfg.value[TIME_WIDTH-1:0];
                CFG_LIMIT:     limit_next     = cfg.value[TIME_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            increment_reg <= '0;
            limit_reg     <= TMAX;
        end
        else
        begin
            increment_reg <= increment_next;
            limit_reg     <= limit_next;
        end
    end

    assign settings.increment = increment_reg;
    assign settings.limit     = limit_reg;

endmodule

// ----- hw/rtl/gtp_charge.sv -----
// ----------------------------------------------------------------------------
// gtp_charge
// Input stage: accepts a request and registers it together with the charge
// unit_count * increment and a flag for a product beyond the time range.
// ----------------------------------------------------------------------------
module gtp_charge
    import gtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gtp_in_if.sink    item,
    input  settings_t settings,
    input  logic      advance,
    output logic      stage_valid,
    output charge_t   stage
);

    localparam int PROD_WIDTH = TIME_WIDTH + COUNT_WIDTH;

    logic                  valid_reg;
    logic                  valid_next;
    charge_t               stage_reg;
    logic                  accept;
    logic [PROD_WIDTH-1:0] product;

    assign item.ready = !valid_reg || advance;
    assign accept     = item.valid && item.ready;

    assign product = PROD_WIDTH'(item.data.unit_count[COUNT_WIDTH-1:0])
                   * PROD_WIDTH'(settings.increment);

    assign valid_next = accept || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.opcode    <= item.data.opcode;
            stage_reg.timestamp <= item.data.timestamp[TIME_WIDTH-1:0];
            stage_reg.charge    <= product[TIME_WIDTH-1:0];
            stage_reg.overflow  <= |product[PROD_WIDTH-1:TIME_WIDTH];
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

// ----- hw/rtl/gtp_bucket.sv -----
// ----------------------------------------------------------------------------
// gtp_bucket
// Bucket stage: holds the policer state, drains or charges the bucket for
// one request per cycle unless result stalls; registers the result beat.
// ----------------------------------------------------------------------------
module gtp_bucket
    import gtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  settings_t settings,
    input  logic      stage_valid,
    input  charge_t   stage,
    output logic      advance,
    gtp_out_if.source result
);

    ticks_t    bucket_reg;
    ticks_t    bucket_next;
    ticks_t    pending_reg;
    ticks_t    pending_next;
    ticks_t    now_reg;
    ticks_t    now_next;
    ticks_t    last_reg;
    ticks_t    last_next;
    logic      alarm_reg;
    logic      alarm_next;
    logic      pend_alarm_reg;
    logic      pend_alarm_next;
    logic      saturated_reg;
    logic      saturated_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_reg;
    out_item_t out_next;

    logic                take;
    ticks_t              elapsed;
    ticks_t              drained;
    logic                empty;
    logic                over;
    ticks_t              excess;
    logic [TIME_WIDTH:0] sum;
    ticks_t              delay;

    assign advance = !out_valid_reg || result.ready;
    assign take    = stage_valid && advance;

    assign elapsed = stage.timestamp - last_reg;
    assign drained = bucket_reg - elapsed;
    assign empty   = bucket_reg <= elapsed;
    assign over    = !empty && (drained > settings.limit);
    assign excess  = drained - settings.limit;
    assign sum     = {1'b0, pending_reg} + {1'b0, stage.charge};

    always_comb
    begin
        bucket_next     = bucket_reg;
        pending_next    = pending_reg;
        now_next        = now_reg;
        last_next       = last_reg;
        alarm_next      = alarm_reg;
        pend_alarm_next = pend_alarm_reg;
        saturated_next  = saturated_reg;
        delay           = '0;
        unique case (stage.opcode)
            OP_EVALUATE:
            begin
                now_next        = stage.timestamp;
                pending_next    = empty ? '0 : drained;
                pend_alarm_next = over;
                delay           = over ? excess : '0;
            end
            OP_COMMIT:
            begin
                last_next  = now_reg;
                alarm_next = pend_alarm_reg;
                if (stage.overflow || sum[TIME_WIDTH])
                begin
                    bucket_next    = TMAX;
                    saturated_next = 1'b1;
                end
                else
                begin
                    bucket_next = sum[TIME_WIDTH-1:0];
                end
            end
            OP_ROLLBACK:
            begin
            end
            OP_RESTART:
            begin
                bucket_next     = '0;
                pending_next    = '0;
                now_next        = stage.timestamp;
                last_next       = stage.timestamp - settings.increment;
                alarm_next      = 1'b0;
                pend_alarm_next = 1'b0;
                saturated_next  = 1'b0;
            end
        endcase
    end

    assign out_next.delay         = FIELD_TIME_WIDTH'(delay);
    assign out_next.pending_alarm = pend_alarm_next;
    assign out_next.admitted      = !alarm_next;
    assign out_next.approximate   = saturated_next;

    assign out_valid_next = take || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_reg     <= '0;
            pending_reg    <= '0;
            now_reg        <= '0;
            last_reg       <= '0;
            alarm_reg      <= 1'b0;
            pend_alarm_reg <= 1'b0;
            saturated_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                bucket_reg     <= bucket_next;
                pending_reg    <= pending_next;
                now_reg        <= now_next;
                last_reg       <= last_next;
                alarm_reg      <= alarm_next;
                pend_alarm_reg <= pend_alarm_next;
                saturated_reg  <= saturated_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

// ----- hw/rtl/gcra_traffic_policer_core.sv -----
// ----------------------------------------------------------------------------
// gcra_traffic_policer_core
// Two-phase GCRA policer: evaluate drains the bucket, commit charges it.
//
//   Channel  Direction  Payload
//   item     in         opcode, timestamp, unit_count
//   result   out        delay, pending_alarm, admitted, approximate
//   cfg      in         index (0 increment, 1 limit), value
//
// One request is accepted every cycle while nothing stalls. The request is
// registered in the charge stage, then its result beat in the bucket stage,
// where it is valid and can be taken.
// A stalled result beat holds the bucket stage; an empty input stage still
// takes one more request, then item.ready falls until the result is taken.
// Reset clears the bucket state, sets increment to zero and limit to all ones.
// Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module gcra_traffic_policer_core
    import gtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gtp_in_if.sink    item,
    gtp_out_if.source result,
    gtp_cfg_if.sink   cfg
);

    settings_t settings;
    logic      stage_valid;
    charge_t   stage;
    logic      advance;

    gtp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    gtp_charge u_charge (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .settings    (settings),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    gtp_bucket u_bucket (
        .clk         (clk),
        .rst_n       (rst_n),
        .settings    (settings),
        .stage_valid (stage_valid),
        .stage       (stage),
        .advance     (advance),
        .result      (result)
    );

    a_delay_has_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.data.delay != '0)) |-> result.data.pending_alarm)
        else $error("Nonzero delay reported without a pending alarm.");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (result.valid && !result.ready && stage_valid))
        else $error("Request channel stalled while the result side was free.");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && advance) |=> result.valid)
        else $error("A request left the input stage without a result beat.");

endmodule

// ----- tb/tb_gcra_traffic_policer_core.sv -----
// ----------------------------------------------------------------------------
// tb_gcra_traffic_policer_core
// Self-checking testbench of the GCRA traffic policer core.
//
// Requests are driven on the item channel with random idle gaps, register
// writes back to back; the result channel stalls at random. A bit-accurate
// predictor of the policer keeps its own bucket, timing and flag state and
// works out the expected result beat for every request at the moment the
// request is accepted. A checker compares each result beat, field by field,
// with the oldest prediction. Directed requests cover the reset settings,
// restart, commit without an evaluate, out-of-order timestamps and both kinds
// of saturation; the random part runs mostly evaluate and commit pairs with
// random content under several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_gcra_traffic_policer_core;
    import gtp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 10;

    logic clk = 1'b0;
    logic rst_n;

    gtp_in_if  item_if ();
    gtp_out_if result_if ();
    gtp_cfg_if cfg_if ();

    gcra_traffic_policer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always #4 clk = ~clk;

    // Predictor state.
    ticks_t inc_reg;
    ticks_t lim_reg;
    ticks_t bkt_lvl;
    ticks_t pend_lvl;
    ticks_t eval_time;
    ticks_t ref_time;
    logic   committed_alarm;
    logic   pend_alarm;
    logic   sticky_sat;

    out_item_t verdict_q[$];

    bit     throttle;
    ticks_t traffic_time;
    int     err_cnt;
    int     sent_cnt;
    int     setting_cnt;
    int     alarm_cnt;
    int     sat_cnt;
    int     quiet_cycles;

    function automatic ticks_t rand_ticks();
        return ticks_t'({$urandom, $urandom});
    endfunction

    function automatic int pick_gap();
        int roll;
        if (!throttle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic ticks_t pick_step();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return ticks_t'($urandom_range(0, 4000));
        if (roll < 9)
            return ticks_t'($urandom);
        return rand_ticks();
    endfunction

    function automatic count_t pick_count();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return count_t'($urandom_range(0, 4));
        if (roll < 9)
            return count_t'($urandom_range(5, 300));
        return count_t'($urandom_range(0, 65535));
    endfunction

    function automatic void rearm_bucket(input ticks_t ts);
        bkt_lvl         = '0;
        pend_lvl        = '0;
        eval_time       = ts;
        ref_time        = ts - inc_reg;
        committed_alarm = 1'b0;
        pend_alarm      = 1'b0;
        sticky_sat      = 1'b0;
    endfunction

    function automatic out_item_t police_request(input in_item_t req);
        ticks_t    ts;
        ticks_t    elapsed;
        ticks_t    cap;
        ticks_t    add;
        ticks_t    n;
        out_item_t v;
        ts = ticks_t'(req.timestamp);
        n  = ticks_t'(count_t'(req.unit_count));
        v  = '0;
        case (req.opcode)
            OP_EVALUATE:
            begin
                pend_alarm = 1'b0;
                eval_time  = ts;
                elapsed    = eval_time - ref_time;
                if (bkt_lvl <= elapsed)
                begin
                    pend_lvl = '0;
                end
                else
                begin
                    pend_lvl = bkt_lvl - elapsed;
                    if (pend_lvl > lim_reg)
                    begin
                        v.delay    = pend_lvl - lim_reg;
                        pend_alarm = 1'b1;
                    end
                end
            end
            OP_COMMIT:
            begin
                cap      = (inc_reg == '0) ? TMAX : TMAX / inc_reg;
                ref_time = eval_time;
                if (n > cap)
                begin
                    bkt_lvl    = TMAX;
                    sticky_sat = 1'b1;
                end
                else
                begin
                    add = n * inc_reg;
                    if (pend_lvl > TMAX - add)
                    begin
                        bkt_lvl    = TMAX;
                        sticky_sat = 1'b1;
                    end
                    else
                    begin
                        bkt_lvl = pend_lvl + add;
                    end
                end
                committed_alarm = pend_alarm;
            end
            OP_RESTART:
            begin
                rearm_bucket(ts);
            end
            default:
            begin
            end
        endcase
        v.pending_alarm = pend_alarm;
        v.admitted      = !committed_alarm;
        v.approximate   = sticky_sat;
        return v;
    endfunction

    task automatic send_request(input opcode_t op, input ticks_t ts, input count_t n);
        int        gap;
        in_item_t  req;
        out_item_t want;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.opcode     = op;
        req.timestamp  = ts;
        req.unit_count = n;
        item_if.valid <= 1'b1;
        item_if.data  <= req;
        do @(posedge clk); while (!item_if.ready);
        want = police_request(req);
        verdict_q.push_back(want);
        sent_cnt++;
        if (op == OP_EVALUATE && want.pending_alarm)
            alarm_cnt++;
        if (want.approximate)
            sat_cnt++;
    endtask

    task automatic wait_all_results();
        item_if.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_settings(input ticks_t new_inc, input ticks_t new_lim);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_INCREMENT;
        cfg_if.value <= new_inc;
        do @(posedge clk); while (!cfg_if.ready);
        inc_reg = new_inc;
        cfg_if.index <= CFG_LIMIT;
        cfg_if.value <= new_lim;
        do @(posedge clk); while (!cfg_if.ready);
        lim_reg = new_lim;
        cfg_if.valid <= 1'b0;
        setting_cnt++;
    endtask

    task automatic test_reset_defaults();
        throttle = 1'b1;
        send_request(OP_EVALUATE, TMAX, '0);
        send_request(OP_COMMIT, '0, count_t'(16'hFFFF));
        send_request(OP_ROLLBACK, '0, '0);
    endtask

    task automatic test_restart_and_order();
        wait_all_results();
        load_settings(ticks_t'(1000), ticks_t'(500));
        send_request(OP_RESTART, '0, '0);
        send_request(OP_COMMIT, TMAX, count_t'(1));
        send_request(OP_EVALUATE, ticks_t'(100), '0);
        send_request(OP_COMMIT, '0, count_t'(3));
        send_request(OP_EVALUATE, ticks_t'(50), '0);
        send_request(OP_ROLLBACK, TMAX, count_t'(16'hFFFF));
        send_request(OP_COMMIT, '0, '0);
    endtask

    task automatic test_saturation();
        wait_all_results();
        load_settings(TMAX, '0);
        send_request(OP_RESTART, TMAX, '0);
        send_request(OP_COMMIT, '0, count_t'(2));
        send_request(OP_RESTART, ticks_t'(5), '0);
        send_request(OP_COMMIT, '0, count_t'(1));
        send_request(OP_EVALUATE, ticks_t'(10), '0);
        send_request(OP_COMMIT, '0, count_t'(1));
        send_request(OP_EVALUATE, '0, '0);
        send_request(OP_RESTART, TMAX, '0);
    endtask

    task automatic run_traffic(input int items);
        int k;
        int roll;
        k = 0;
        while (k < items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
            begin
                traffic_time += pick_step();
                send_request(OP_EVALUATE, traffic_time, count_t'($urandom_range(0, 65535)));
                if ($urandom_range(0, 4) != 0)
                    send_request(OP_COMMIT, rand_ticks(), pick_count());
                else
                    send_request(OP_ROLLBACK, rand_ticks(), pick_count());
                k += 2;
            end
            else if (roll < 80)
            begin
                if ($urandom_range(0, 1) != 0)
                    traffic_time = rand_ticks();
                send_request(OP_RESTART, traffic_time, count_t'($urandom_range(0, 65535)));
                k++;
            end
            else
            begin
                send_request(opcode_t'($urandom_range(0, 3)), rand_ticks(),
                             count_t'($urandom_range(0, 65535)));
                k++;
            end
        end
    endtask

    task automatic test_pressure_pause();
        throttle = 1'b1;
        run_traffic(20);
        wait_all_results();
        run_traffic(20);
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        ticks_t new_inc;
        ticks_t new_lim;
        for (int p = 0; p < phases; p++)
        begin
            case (p % 8)
                0:
                begin
                    new_inc = '0;
                    new_lim = TMAX;
                end
                1:
                begin
                    new_inc = TMAX;
                    new_lim = '0;
                end
                2:
                begin
                    new_inc = ticks_t'($urandom_range(1, 1000));
                    new_lim = ticks_t'($urandom_range(0, 5000));
                end
                3:
                begin
                    new_inc = rand_ticks();
                    new_lim = rand_ticks();
                end
                4:
                begin
                    new_inc = ticks_t'(1);
                    new_lim = '0;
                end
                5:
                begin
                    new_inc = ticks_t'($urandom_range(1, 1000));
                    new_lim = TMAX;
                end
                6:
                begin
                    new_inc = ticks_t'(1) << $urandom_range(0, TIME_WIDTH - 1);
                    new_lim = rand_ticks();
                end
                default:
                begin
                    new_inc = ticks_t'($urandom_range(1, 50));
                    new_lim = ticks_t'($urandom_range(0, 200));
                end
            endcase
            throttle = (p % 4 != 3);
            wait_all_results();
            load_settings(new_inc, new_lim);
            traffic_time = rand_ticks();
            send_request(OP_RESTART, traffic_time, '0);
            run_traffic(per_phase);
        end
    endtask

    initial
    begin
        item_if.valid = 1'b0;
        item_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_INCREMENT;
        cfg_if.value  = '0;
        rst_n         = 1'b0;
        throttle      = 1'b1;
        traffic_time  = '0;
        err_cnt       = 0;
        sent_cnt      = 0;
        setting_cnt   = 0;
        alarm_cnt     = 0;
        sat_cnt       = 0;
        inc_reg       = '0;
        lim_reg       = TMAX;
        rearm_bucket('0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_restart_and_order();
        test_saturation();
        test_pressure_pause();
        test_random_traffic(8, 150);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d requests of all four opcodes under %0d register settings.",
                 sent_cnt, setting_cnt);
        $display("Predicted %0d nonconforming evaluations and %0d saturated result beats.",
                 alarm_cnt, sat_cnt);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int stall_left;
        stall_left     = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_if.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        out_item_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = result_if.data;
            if (verdict_q.size() == 0)
            begin
                $error("Result beat arrived with no request outstanding.");
                err_cnt++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (got.delay !== want.delay)
                begin
                    $error("delay mismatch: expected %h, got %h", want.delay, got.delay);
                    err_cnt++;
                end
                if (got.pending_alarm !== want.pending_alarm)
                begin
                    $error("pending_alarm mismatch: expected %b, got %b",
                           want.pending_alarm, got.pending_alarm);
                    err_cnt++;
                end
                if (got.admitted !== want.admitted)
                begin
                    $error("admitted mismatch: expected %b, got %b",
                           want.admitted, got.admitted);
                    err_cnt++;
                end
                if (got.approximate !== want.approximate)
                begin
                    $error("approximate mismatch: expected %b, got %b",
                           want.approximate, got.approximate);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_if.valid && item_if.ready) ||
            (result_if.valid && result_if.ready) || (cfg_if.valid && cfg_if.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
hw/rtl/gtp_pkg.sv
hw/rtl/gtp_in_if.sv
hw/rtl/gtp_out_if.sv
hw/rtl/gtp_cfg_if.sv
hw/rtl/gtp_cfg_regs.sv
hw/rtl/gtp_charge.sv
hw/rtl/gtp_bucket.sv
hw/rtl/gcra_traffic_policer_core.sv
tb/tb_gcra_traffic_policer_core.sv
